[hdl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and constants shared by the beamformer power accumulator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
   localparam int N_BEAMS_DEF = 8;
   localparam int N_ANT_DEF = 64;
   localparam int N_FREQ_DEF = 16;
   localparam int ACC_W = 26;
   localparam int POW_W = 53;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [0:0] REG_ANT_COUNT = 1'b0;
   localparam logic [0:0] REG_BEAM_COUNT = 1'b1;

   typedef struct packed {
      logic opcode;
      logic [3:0] freq_channel;
      logic [5:0] antenna;
      logic [2:0] beam_sel;
      logic signed [15:0] weight_re;
      logic signed [15:0] weight_im;
      logic signed [3:0] volt_re;
      logic signed [3:0] volt_im;
   } req_type;

   typedef struct packed {
      logic [2:0] beam_out;
      logic [3:0] freq_out;
      logic [52:0] intensity;
      logic last_beam;
   } rsp_type;

   // token handed from cell to cell along the beam chain
   typedef struct packed {
      logic valid;
      logic restart;
      logic emit;
      logic last;
      logic signed [15:0] w_re;
      logic signed [15:0] w_im;
   } tok_type;
endpackage
`default_nettype wire

[hdl/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/bpa_cell.sv]
// ----------------------------------------------------------------------------
// bpa_cell
// One beam cell: holds one complex accumulator, passes the weight token on.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_cell import bpa_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic signed [3:0] v_re,
   input wire logic signed [3:0] v_im,
   input wire tok_type tok_i,
   output tok_type tok_o,
   output logic signed [ACC_W-1:0] acc_re,
   output logic signed [ACC_W-1:0] acc_im
);
   logic signed [ACC_W-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [20:0] pr, pi;
   tok_type tok_ff;

   // complex product of weight and voltage, accumulated on a valid token
   always_comb begin
      pr = 21'(tok_i.w_re * v_re) - 21'(tok_i.w_im * v_im);
      pi = 21'(tok_i.w_re * v_im) + 21'(tok_i.w_im * v_re);
      re_in = re_ff;
      im_in = im_ff;
      if (tok_i.valid) begin
         re_in = (tok_i.restart ? '0 : re_ff) + ACC_W'(pr);
         im_in = (tok_i.restart ? '0 : im_ff) + ACC_W'(pi);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         re_ff <= '0;
         im_ff <= '0;
         tok_ff <= '0;
      end else begin
         re_ff <= re_in;
         im_ff <= im_in;
         tok_ff <= tok_i;
      end
   end

   assign tok_o = tok_ff;
   assign acc_re = re_ff;
   assign acc_im = im_ff;
endmodule
`default_nettype wire

[hdl/bpa_power.sv]
// ----------------------------------------------------------------------------
// bpa_power
// Squared magnitude of one beam sum, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_power import bpa_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   input wire logic [2:0] in_beam,
   input wire logic [3:0] in_freq,
   input wire logic in_last,
   input wire logic signed [ACC_W-1:0] in_re,
   input wire logic signed [ACC_W-1:0] in_im,
   output logic out_valid,
   output rsp_type out_rsp
);
   logic v1_ff, v2_ff;
   logic [51:0] rr_ff, ii_ff;
   rsp_type m1_ff, m2_ff;

   // square each part, then add
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      rr_ff <= 52'(in_re * in_re);
      ii_ff <= 52'(in_im * in_im);
      m1_ff <= '{beam_out: in_beam, freq_out: in_freq, intensity: '0, last_beam: in_last};
      m2_ff <= '{beam_out: m1_ff.beam_out, freq_out: m1_ff.freq_out,
                 intensity: POW_W'(rr_ff) + POW_W'(ii_ff), last_beam: m1_ff.last_beam};
   end

   assign out_valid = v2_ff;
   assign out_rsp = m2_ff;
endmodule
`default_nettype wire

[hdl/beamformer_power_accumulator.sv]
// ----------------------------------------------------------------------------
// beamformer_power_accumulator
// Complex weight table and a chain of beam cells forming power per beam.
// ----------------------------------------------------------------------------
// A sample walks the chain of beam cells, one cell per cycle, fed by a weight table
// read one beam per cycle; busy is held through the walk; weight loads leave it low.
// An emitting sample then sends beam_count results (clamped to 1..N_BEAMS), one per
// cycle, through the power unit; busy lasts until the power pipe has drained.
// The receiver cannot stall. Reset is synchronous and clears accumulators and
// control; the weight table is undefined until written.
`default_nettype none
module beamformer_power_accumulator import bpa_pkg::*; #(
   parameter int N_BEAMS = N_BEAMS_DEF,
   parameter int N_ANT = N_ANT_DEF,
   parameter int N_FREQ = N_FREQ_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [2:0] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam int BW = (N_BEAMS > 1) ? $clog2(N_BEAMS) : 1;
   localparam int FW = (N_FREQ > 1) ? $clog2(N_FREQ) : 1;
   localparam int AW = (N_ANT > 1) ? $clog2(N_ANT) : 1;
   localparam int DEPTH = N_BEAMS * N_FREQ * N_ANT;
   localparam int DW = $clog2(DEPTH + 1);
   localparam int CW = $clog2(N_BEAMS + 4) + 1;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} state_type;

   state_type state_ff;
   logic [6:0] ant_cnt_ff;
   logic [3:0] beam_cnt_ff;
   logic [6:0] na;
   logic [6:0] nb;
   logic [CW-1:0] cnt_ff;
   logic [6:0] rd_beam_ff;
   logic [6:0] em_beam_ff;
   logic rd_act_ff;
   logic restart_ff, emit_ff;
   logic [3:0] freq_ff;
   logic signed [3:0] vre_ff, vim_ff;

   // register file
   always_comb begin
      na = (ant_cnt_ff == 0) ? 7'd1 : (32'(ant_cnt_ff) > N_ANT ? 7'(N_ANT) : ant_cnt_ff);
      nb = (beam_cnt_ff == 0) ? 7'd1 :
           (32'(beam_cnt_ff) > N_BEAMS ? 7'(N_BEAMS) : {3'd0, beam_cnt_ff});
   end
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_BEAM_COUNT) ? {28'd0, beam_cnt_ff} : {25'd0, ant_cnt_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         ant_cnt_ff <= 7'd64;
         beam_cnt_ff <= 4'd8;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_ANT_COUNT: ant_cnt_ff <= pwdata[6:0];
            REG_BEAM_COUNT: beam_cnt_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // request decode
   logic acc;
   logic ok_load, ok_samp;
   assign acc = start && !busy;
   assign ok_load = (32'(req_data.beam_sel) < N_BEAMS) && (32'(req_data.freq_channel) < N_FREQ)
                    && (32'(req_data.antenna) < N_ANT);
   assign ok_samp = (32'(req_data.freq_channel) < N_FREQ) && (32'(req_data.antenna) < N_ANT);

   logic [FW-1:0] fidx;
   logic [AW-1:0] aidx;
   logic [BW-1:0] bidx;
   logic [31:0] rd_addr32;
   logic [DW-1:0] wa, ra;
   logic [31:0] rdat;
   assign fidx = FW'(req_data.freq_channel);
   assign aidx = AW'(req_data.antenna);
   assign bidx = BW'(req_data.beam_sel);
   assign wa = DW'((32'(bidx) * N_FREQ + 32'(fidx)) * N_ANT + 32'(aidx));
   logic [5:0] ant_ff;
   assign rd_addr32 = (32'(rd_beam_ff) * N_FREQ + 32'(freq_ff)) * N_ANT + 32'(ant_ff);
   assign ra = DW'(rd_addr32);

   bpa_ram #(.WIDTH(32), .DEPTH(DEPTH + 1)) u_tab (
      .clock(clock),
      .wr_en(acc && req_data.opcode == OP_LOAD && ok_load),
      .wr_addr(wa),
      .wr_data({req_data.weight_im, req_data.weight_re}),
      .rd_addr(ra),
      .rd_data(rdat)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rd_act_ff <= 1'b0;
         rd_beam_ff <= '0;
         em_beam_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               rd_beam_ff <= '0;
               if (acc && req_data.opcode == OP_SAMPLE && ok_samp) begin
                  state_ff <= S_RUN;
                  rd_act_ff <= 1'b1;
                  cnt_ff <= '0;
               end
            end
            S_RUN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (32'(rd_beam_ff) + 1 >= N_BEAMS) rd_act_ff <= 1'b0;
               else rd_beam_ff <= rd_beam_ff + 1'b1;
               if (32'(cnt_ff) == N_BEAMS + 1) begin
                  em_beam_ff <= '0;
                  state_ff <= emit_ff ? S_EMIT : S_IDLE;
               end
            end
            S_EMIT: begin
               em_beam_ff <= em_beam_ff + 1'b1;
               if (em_beam_ff + 1'b1 == nb) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         freq_ff <= req_data.freq_channel;
         ant_ff <= req_data.antenna;
         vre_ff <= req_data.volt_re;
         vim_ff <= req_data.volt_im;
         restart_ff <= req_data.antenna == 6'd0;
         emit_ff <= {1'b0, req_data.antenna} == na - 7'd1;
      end
   end

   // busy through the chain walk and the emission; power pipe drains behind
   logic [1:0] tail_ff;
   always_ff @(posedge clock) begin
      if (reset) tail_ff <= '0;
      else if (state_ff == S_EMIT) tail_ff <= 2'd3;
      else if (tail_ff != 0) tail_ff <= tail_ff - 1'b1;
   end
   assign busy = (state_ff != S_IDLE) || (tail_ff != 0);

   // cell chain
   tok_type tok [N_BEAMS+1];
   logic signed [ACC_W-1:0] are [N_BEAMS];
   logic signed [ACC_W-1:0] aim [N_BEAMS];
   logic rd_v_ff;
   logic [6:0] rd_b_ff;
   always_ff @(posedge clock) begin
      if (reset) rd_v_ff <= 1'b0;
      else rd_v_ff <= state_ff == S_RUN && rd_act_ff;
      rd_b_ff <= rd_beam_ff;
   end

   genvar g;
   generate
      for (g = 0; g < N_BEAMS; g++) begin : g_cell
         tok_type ti;
         always_comb begin
            ti = tok[g];
            ti.valid = tok[g].valid && (32'(rd_b_ff) == g) && (32'(rd_b_ff) < 32'(nb));
            ti.w_re = rdat[15:0];
            ti.w_im = rdat[31:16];
            ti.restart = restart_ff;
         end
         bpa_cell u_cell (
            .clock(clock), .reset(reset), .v_re(vre_ff), .v_im(vim_ff),
            .tok_i(ti), .tok_o(tok[g+1]), .acc_re(are[g]), .acc_im(aim[g])
         );
      end
   endgenerate
   always_comb begin
      tok[0] = '0;
      tok[0].valid = rd_v_ff;
      tok[0].emit = emit_ff;
      tok[0].last = 1'b0;
   end
   logic unused_tok;
   assign unused_tok = ^tok[N_BEAMS];

   // emission through the power unit
   bpa_power u_pow (
      .clock(clock), .reset(reset),
      .in_valid(state_ff == S_EMIT),
      .in_beam(3'(em_beam_ff)),
      .in_freq(freq_ff),
      .in_last(em_beam_ff + 1'b1 == nb),
      .in_re(are[BW'(em_beam_ff)]),
      .in_im(aim[BW'(em_beam_ff)]),
      .out_valid(rsp_valid),
      .out_rsp(rsp_data)
   );
endmodule
`default_nettype wire

[hdl/bpa_checker.sv]
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the beamformer power accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_checker import bpa_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire rsp_type rsp_data,
   input wire logic pready
);
   // no result comes out of reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid) else $error("rsp after reset");
   // block is busy while results go out
   a_busy: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("rsp while idle");
   // busy only rises after a request
   a_start: assert property (@(posedge clock) disable iff (reset) $rose(busy) |-> $past(start))
      else $error("busy without request");
   // beams ascend within a run
   a_ord: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_beam |=>
         rsp_valid && rsp_data.beam_out == $past(rsp_data.beam_out) + 3'd1)
      else $error("beam order");
   // port never stalls
   a_rdy: assert property (@(posedge clock) pready) else $error("pready low");
endmodule

bind beamformer_power_accumulator bpa_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data), .pready(pready)
);
`default_nettype wire
